### hdl/kalman_angle_bias_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle/bias filter core
// Clocked on aclk; the first form is gated by reset, the second is not.
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_BIAS_FILTER_CORE_MACROS_SVH
`define KALMAN_ANGLE_BIAS_FILTER_CORE_MACROS_SVH

`ifndef SYNTH
`define KABF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("kabf assertion failed");
`define KABF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("kabf assertion failed");
`else
`define KABF_ASSERT(lbl, prop)
`define KABF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### hdl/kabf_pkg.sv
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared types, codes and saturation helpers of the angle/bias filter core.
// ----------------------------------------------------------------------------
package kabf_pkg;

    localparam int DataW   = 32;
    localparam int DtW     = 24;
    localparam int NoiseW  = 31;
    localparam int InW     = 88;
    localparam int CfgIdxW = 2;
    localparam int CntW    = 6;

    localparam logic [NoiseW-1:0] RESET_ANGLE_NOISE   = 31'd268435;
    localparam logic [NoiseW-1:0] RESET_BIAS_NOISE    = 31'd805306;
    localparam logic [NoiseW-1:0] RESET_MEASURE_NOISE = 31'd8053064;

    localparam logic [CfgIdxW-1:0] CFG_ANGLE_NOISE   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_BIAS_NOISE    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MEASURE_NOISE = 2'd2;

    // multiplier operand selects
    localparam logic [3:0] MUL_DT_P11   = 4'd0;
    localparam logic [3:0] MUL_DT_RATE  = 4'd1;
    localparam logic [3:0] MUL_DT_BN    = 4'd2;
    localparam logic [3:0] MUL_DT_INNER = 4'd3;
    localparam logic [3:0] MUL_K0_Y     = 4'd4;
    localparam logic [3:0] MUL_K1_Y     = 4'd5;
    localparam logic [3:0] MUL_K0_P00   = 4'd6;
    localparam logic [3:0] MUL_K0_P01   = 4'd7;
    localparam logic [3:0] MUL_K1_P00   = 4'd8;
    localparam logic [3:0] MUL_K1_P01   = 4'd9;

    // writeback targets of the rounded product
    localparam logic [3:0] WB_NONE      = 4'd0;
    localparam logic [3:0] WB_M11       = 4'd1;
    localparam logic [3:0] WB_ANGLE_ADD = 4'd2;
    localparam logic [3:0] WB_P11_ADD   = 4'd3;
    localparam logic [3:0] WB_P00_ADD   = 4'd4;
    localparam logic [3:0] WB_BIAS_ADD  = 4'd5;
    localparam logic [3:0] WB_P00_SUB   = 4'd6;
    localparam logic [3:0] WB_P01_SUB   = 4'd7;
    localparam logic [3:0] WB_P10_SUB   = 4'd8;
    localparam logic [3:0] WB_P11_SUB   = 4'd9;

    typedef struct packed {
        logic       load;
        logic       rate_calc;
        logic       inner_calc;
        logic       inno_calc;
        logic       div_init;
        logic       div_step;
        logic       div_fin;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic [3:0] wb_sel;
        logic       out_load;
    } cmd_t;

    localparam logic signed [45:0] SatMax = 46'sd2147483647;
    localparam logic signed [45:0] SatMin = -46'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        logic signed [31:0] r;
        if (v > SatMax) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SatMin) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [45:0] sx46(input logic signed [31:0] v);
        return {{14{v[31]}}, v};
    endfunction

endpackage

### hdl/kabf_ctrl.sv
// ----------------------------------------------------------------------------
// kabf_ctrl
// Sequencer: walks the fixed predict/divide/correct schedule and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
`include "kalman_angle_bias_filter_core_macros.svh"

module kabf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output kabf_pkg::cmd_t  cmd
);
    import kabf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [CntW-1:0] DivFirst = 6'd9;
    localparam logic [CntW-1:0] DivLast  = 6'd40;
    localparam logic [CntW-1:0] LastCnt  = 6'd49;

    logic [1:0]      state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            mvalid_reg, mvalid_next;
    logic            accept, out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN: begin
                cnt_next = cnt_reg + 6'd1;
                case (cnt_reg)
                    6'd0: begin
                        cmd.rate_calc = 1'b1;
                        cmd.mul_en    = 1'b1;
                        cmd.mul_sel   = MUL_DT_P11;
                    end
                    6'd1: begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_DT_RATE;
                    end
                    6'd2: begin
                        cmd.wb_sel  = WB_M11;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_DT_BN;
                    end
                    6'd3: begin
                        cmd.wb_sel     = WB_ANGLE_ADD;
                        cmd.inner_calc = 1'b1;
                    end
                    6'd4: begin
                        cmd.wb_sel  = WB_P11_ADD;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_DT_INNER;
                    end
                    6'd6: cmd.wb_sel = WB_P00_ADD;
                    6'd7: cmd.inno_calc = 1'b1;
                    6'd8: cmd.div_init = 1'b1;
                    6'd41: cmd.div_fin = 1'b1;
                    6'd42: begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_K0_Y;
                    end
                    6'd43: begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_K1_Y;
                    end
                    // first row is read before it is corrected
                    6'd44: begin
                        cmd.wb_sel  = WB_ANGLE_ADD;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_K1_P00;
                    end
                    6'd45: begin
                        cmd.wb_sel  = WB_BIAS_ADD;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_K1_P01;
                    end
                    6'd46: begin
                        cmd.wb_sel  = WB_P10_SUB;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_K0_P00;
                    end
                    6'd47: begin
                        cmd.wb_sel  = WB_P11_SUB;
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = MUL_K0_P01;
                    end
                    6'd48: cmd.wb_sel = WB_P00_SUB;
                    6'd49: begin
                        cmd.wb_sel = WB_P01_SUB;
                        if (out_free) begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end else begin
                            state_next = ST_HOLD;
                        end
                    end
                    default: ;
                endcase
                if (cnt_reg >= DivFirst && cnt_reg <= DivLast) begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    `KABF_ASSERT(a_accept_starts, (s_tvalid && s_tready) |=> (state_reg == ST_RUN && cnt_reg == 6'd0))
    `KABF_ASSERT(a_out_no_overwrite, cmd.out_load |-> (!mvalid_reg || m_tready))
    `KABF_ASSERT(a_cnt_bound, (state_reg == ST_RUN) |-> (cnt_reg <= LastCnt))
    `KABF_ASSERT_ALWAYS(a_div_cmds_exclusive, $onehot0({cmd.div_init, cmd.div_step, cmd.div_fin}))

endmodule

### hdl/kabf_dp.sv
// ----------------------------------------------------------------------------
// kabf_dp
// Datapath: filter state, noise registers, one shared multiplier with a
// rounding stage, and a two-lane restoring divider for the gains.
// ----------------------------------------------------------------------------
module kabf_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [kabf_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [kabf_pkg::NoiseW-1:0]        cfg_data,
    input  logic [kabf_pkg::InW-1:0]           s_tdata,
    input  kabf_pkg::cmd_t                     cmd,
    output logic [kabf_pkg::DataW-1:0]         m_tdata
);
    import kabf_pkg::*;

    localparam logic signed [67:0] Half24 = 68'sd8388608;
    localparam logic signed [67:0] Half28 = 68'sd134217728;

    logic [NoiseW-1:0] apn_reg, bpn_reg, mn_reg;
    logic signed [31:0] ma_reg, mr_reg;
    logic [DtW-1:0] dt_reg;
    logic signed [31:0] angle_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] rate_reg, y_reg, k0_reg, k1_reg, out_reg;
    logic signed [43:0] m11_reg, rnd_reg;
    logic signed [35:0] inner_reg;
    logic signed [32:0] s_reg;
    logic signed [67:0] prod_reg;
    logic sh28_reg;

    logic [63:0] den_reg, rem0_reg, rem1_reg;
    logic [31:0] q0_reg, q1_reg;
    logic ovf0_reg, ovf1_reg, neg0_reg, neg1_reg, dzero_reg;

    logic signed [35:0] mul_a;
    logic signed [31:0] mul_b, dt_ext;
    logic signed [67:0] prod_full, rsum, rsh;
    logic mul_sh28;
    logic signed [45:0] rnd_x, m11_x, inner_full;
    logic [32:0] den_abs;
    logic [31:0] p00_abs, p10_abs;

    assign dt_ext = {8'd0, dt_reg};
    assign m_tdata = out_reg;

    always_comb begin
        mul_a    = {{4{k0_reg[31]}}, k0_reg};
        mul_b    = y_reg;
        mul_sh28 = 1'b1;
        case (cmd.mul_sel)
            MUL_DT_P11: begin
                mul_a = {{4{p11_reg[31]}}, p11_reg}; mul_b = dt_ext; mul_sh28 = 1'b0;
            end
            MUL_DT_RATE: begin
                mul_a = {{4{rate_reg[31]}}, rate_reg}; mul_b = dt_ext; mul_sh28 = 1'b0;
            end
            MUL_DT_BN: begin
                mul_a = {5'd0, bpn_reg}; mul_b = dt_ext; mul_sh28 = 1'b0;
            end
            MUL_DT_INNER: begin
                mul_a = inner_reg; mul_b = dt_ext; mul_sh28 = 1'b0;
            end
            MUL_K0_Y:   begin mul_a = {{4{k0_reg[31]}}, k0_reg}; mul_b = y_reg;   end
            MUL_K1_Y:   begin mul_a = {{4{k1_reg[31]}}, k1_reg}; mul_b = y_reg;   end
            MUL_K0_P00: begin mul_a = {{4{k0_reg[31]}}, k0_reg}; mul_b = p00_reg; end
            MUL_K0_P01: begin mul_a = {{4{k0_reg[31]}}, k0_reg}; mul_b = p01_reg; end
            MUL_K1_P00: begin mul_a = {{4{k1_reg[31]}}, k1_reg}; mul_b = p00_reg; end
            MUL_K1_P01: begin mul_a = {{4{k1_reg[31]}}, k1_reg}; mul_b = p01_reg; end
            default: ;
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // round to nearest, ties up
    assign rsum = prod_reg + (sh28_reg ? Half28 : Half24);
    assign rsh  = sh28_reg ? (rsum >>> 28) : (rsum >>> 24);

    assign rnd_x = {{2{rnd_reg[43]}}, rnd_reg};
    assign m11_x = {{2{m11_reg[43]}}, m11_reg};
    assign inner_full = m11_x - sx46(p01_reg) - sx46(p10_reg) + {15'd0, apn_reg};

    assign den_abs = s_reg[32] ? 33'(-s_reg) : 33'(s_reg);
    assign p00_abs = p00_reg[31] ? 32'(-p00_reg) : 32'(p00_reg);
    assign p10_abs = p10_reg[31] ? 32'(-p10_reg) : 32'(p10_reg);

    function automatic logic signed [31:0] gain_fin(input logic [31:0] q, input logic ovf,
                                                    input logic neg, input logic dz);
        logic signed [31:0] r;
        if (dz) begin
            r = '0;
        end else if (ovf || q[31]) begin
            r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = neg ? -$signed(q) : $signed(q);
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apn_reg   <= RESET_ANGLE_NOISE;
            bpn_reg   <= RESET_BIAS_NOISE;
            mn_reg    <= RESET_MEASURE_NOISE;
            angle_reg <= '0;
            bias_reg  <= '0;
            p00_reg   <= '0;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ANGLE_NOISE:   apn_reg <= cfg_data;
                    CFG_BIAS_NOISE:    bpn_reg <= cfg_data;
                    CFG_MEASURE_NOISE: mn_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.inner_calc) begin
                p01_reg <= sat32(sx46(p01_reg) - m11_x);
                p10_reg <= sat32(sx46(p10_reg) - m11_x);
            end
            case (cmd.wb_sel)
                WB_ANGLE_ADD: angle_reg <= sat32(sx46(angle_reg) + rnd_x);
                WB_BIAS_ADD:  bias_reg  <= sat32(sx46(bias_reg) + rnd_x);
                WB_P00_ADD:   p00_reg   <= sat32(sx46(p00_reg) + rnd_x);
                WB_P11_ADD:   p11_reg   <= sat32(sx46(p11_reg) + rnd_x);
                WB_P00_SUB:   p00_reg   <= sat32(sx46(p00_reg) - rnd_x);
                WB_P01_SUB:   p01_reg   <= sat32(sx46(p01_reg) - rnd_x);
                WB_P10_SUB:   p10_reg   <= sat32(sx46(p10_reg) - rnd_x);
                WB_P11_SUB:   p11_reg   <= sat32(sx46(p11_reg) - rnd_x);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ma_reg <= s_tdata[31:0];
            mr_reg <= s_tdata[63:32];
            dt_reg <= s_tdata[87:64];
        end
        if (cmd.rate_calc) begin
            rate_reg <= sat32(sx46(mr_reg) - sx46(bias_reg));
        end
        if (cmd.wb_sel == WB_M11) begin
            m11_reg <= rnd_reg;
        end
        if (cmd.inner_calc) begin
            inner_reg <= inner_full[35:0];
        end
        if (cmd.inno_calc) begin
            s_reg <= {p00_reg[31], p00_reg} + {2'b00, mn_reg};
            y_reg <= sat32(sx46(ma_reg) - sx46(angle_reg));
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_full;
            sh28_reg <= mul_sh28;
        end
        rnd_reg <= rsh[43:0];
        if (cmd.div_init) begin
            den_reg   <= {den_abs, 31'd0};
            rem0_reg  <= {4'd0, p00_abs, 28'd0};
            rem1_reg  <= {4'd0, p10_abs, 28'd0};
            ovf0_reg  <= {5'd0, p00_abs, 28'd0} >= {den_abs, 32'd0};
            ovf1_reg  <= {5'd0, p10_abs, 28'd0} >= {den_abs, 32'd0};
            neg0_reg  <= p00_reg[31] ^ s_reg[32];
            neg1_reg  <= p10_reg[31] ^ s_reg[32];
            dzero_reg <= (s_reg == '0);
            q0_reg    <= '0;
            q1_reg    <= '0;
        end
        if (cmd.div_step) begin
            den_reg <= den_reg >> 1;
            if (rem0_reg >= den_reg) begin
                rem0_reg <= rem0_reg - den_reg;
                q0_reg   <= {q0_reg[30:0], 1'b1};
            end else begin
                q0_reg   <= {q0_reg[30:0], 1'b0};
            end
            if (rem1_reg >= den_reg) begin
                rem1_reg <= rem1_reg - den_reg;
                q1_reg   <= {q1_reg[30:0], 1'b1};
            end else begin
                q1_reg   <= {q1_reg[30:0], 1'b0};
            end
        end
        if (cmd.div_fin) begin
            k0_reg <= gain_fin(q0_reg, ovf0_reg, neg0_reg, dzero_reg);
            k1_reg <= gain_fin(q1_reg, ovf1_reg, neg1_reg, dzero_reg);
        end
        if (cmd.out_load) begin
            out_reg <= angle_reg;
        end
    end

endmodule

### hdl/kalman_angle_bias_filter_core.sv
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_core
// Two-state angle/gyro-bias Kalman filter, one angle estimate per sample.
//
//   channel  direction  payload
//   s_       in         measured_angle, measured_rate, time_step
//   m_       out        angle_estimate
//   cfg_     in         noise register index and value
//
// Each sample runs from accept to a valid result through prediction on the
// shared multiplier, the two-lane bit-per-cycle gain divider, and the
// correction. s_tready rises again the cycle after, so a new sample is taken
// only once the last one is through; a stalled output holds the last
// cycle and keeps s_tready low until the result register frees up.
// Reset is synchronous on aresetn low, clears the state and reloads the noise registers' reset values.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [kabf_pkg::InW-1:0]     s_tdata,   // measured_angle, measured_rate, time_step
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [kabf_pkg::DataW-1:0]   m_tdata,   // angle_estimate
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [kabf_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [kabf_pkg::NoiseW-1:0]  cfg_data
);
    import kabf_pkg::*;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    kabf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    kabf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tdata   (m_tdata)
    );

endmodule

### bench/kalman_checker.sv
// ----------------------------------------------------------------------------
// kalman_checker
// Watches the sample, result and noise-register channels of the filter core,
// runs its own fixed-point model of the filter and compares every estimate.
// ----------------------------------------------------------------------------
module kalman_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [kabf_pkg::InW-1:0]     s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [kabf_pkg::DataW-1:0]   m_tdata,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [kabf_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [kabf_pkg::NoiseW-1:0]  cfg_data,
    output int                           fail_count,
    output int                           pending,
    output int                           estimates_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import kabf_pkg::*;

    logic [NoiseW-1:0] q_angle, q_bias, r_meas;
    longint est_angle, est_bias, p00, p01, p10, p11;
    logic [31:0] expected_estimates[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // round to nearest, ties up: arithmetic shift of a biased product
    function automatic longint mul_rnd(input longint a, input longint b, input int sh);
        longint p;
        p = a * b + (64'sd1 <<< (sh - 1));
        return p >>> sh;
    endfunction

    task automatic filter_sample(input logic [InW-1:0] word);
        longint m_angle, m_rate, dt, rate, inner, s, k0, k1, y, d11;
        longint a00, a01, a10, a11;
        m_angle = longint'($signed(word[31:0]));
        m_rate  = longint'($signed(word[63:32]));
        dt      = longint'({40'd0, word[87:64]});
        // predict
        rate      = clamp32(m_rate - est_bias);
        est_angle = clamp32(est_angle + mul_rnd(dt, rate, 24));
        d11   = mul_rnd(dt, p11, 24);
        inner = d11 - p01 - p10 + longint'(q_angle);
        a00 = clamp32(p00 + mul_rnd(dt, inner, 24));
        a01 = clamp32(p01 - d11);
        a10 = clamp32(p10 - d11);
        a11 = clamp32(p11 + mul_rnd(longint'(q_bias), dt, 24));
        // gains, truncated toward zero
        s = a00 + longint'(r_meas);
        if (s == 0) begin
            k0 = 0;
            k1 = 0;
        end else begin
            k0 = clamp32((a00 * (64'sd1 <<< 28)) / s);
            k1 = clamp32((a10 * (64'sd1 <<< 28)) / s);
        end
        // correct, first row taken from before the update
        y = clamp32(m_angle - est_angle);
        est_angle = clamp32(est_angle + mul_rnd(k0, y, 28));
        est_bias  = clamp32(est_bias + mul_rnd(k1, y, 28));
        p00 = clamp32(a00 - mul_rnd(k0, a00, 28));
        p01 = clamp32(a01 - mul_rnd(k0, a01, 28));
        p10 = clamp32(a10 - mul_rnd(k1, a00, 28));
        p11 = clamp32(a11 - mul_rnd(k1, a01, 28));
        expected_estimates.push_back(est_angle[31:0]);
    endtask

    assign pending = expected_estimates.size();

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            q_angle = RESET_ANGLE_NOISE;
            q_bias  = RESET_BIAS_NOISE;
            r_meas  = RESET_MEASURE_NOISE;
            est_angle = 0; est_bias = 0;
            p00 = 0; p01 = 0; p10 = 0; p11 = 0;
            expected_estimates.delete();
            fail_count = 0;
            estimates_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ANGLE_NOISE:   q_angle = cfg_data;
                    CFG_BIAS_NOISE:    q_bias  = cfg_data;
                    CFG_MEASURE_NOISE: r_meas  = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                estimates_seen++;
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected estimate, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: angle_estimate mismatch, expected %h, actual %h",
                                 $time, want, m_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) filter_sample(s_tdata);
        end
    end
endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives samples and noise-register writes into the angle/bias filter core
// with random idle bursts and a long output stall; the checker scores it.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kabf_pkg::*;

    localparam int StallLimit = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready;
    logic [InW-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 1'b0;
    logic [DataW-1:0] m_tdata;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [NoiseW-1:0] cfg_data = '0;
    int fail_count, pending, estimates_seen;
    int samples_sent = 0, writes_done = 0, idle_cycles = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    always #5 aclk = ~aclk;

    kalman_angle_bias_filter_core u_top (.*);

    kalman_checker u_chk (.*);

    // watchdog: count cycles with no word moving on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver: random stall bursts, none in the calm tail
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // valid stays up from one word into the next unless an idle burst comes between
    task automatic send_sample(input logic [31:0] ang, input logic [31:0] rt,
                               input logic [23:0] dt);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tdata  <= {dt, rt, ang};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        samples_sent++;
    endtask

    task automatic write_noise(input logic [CfgIdxW-1:0] idx, input logic [NoiseW-1:0] val);
        s_tvalid <= 1'b0;
        // drain: wait for every estimate, then a margin past one sample's latency
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        writes_done++;
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 180 << 16)) - (90 << 16));
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic logic [23:0] rand_dt();
        case ($urandom_range(0, 4))
            0: return 24'($urandom());
            default: return 24'($urandom_range(8000, 40000));
        endcase
    endfunction

    initial begin
        int phase;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: field extremes, zero step, saturation
        send_sample(32'h0000_0000, 32'h0000_0000, 24'h000000);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF);
        send_sample(32'h8000_0000, 32'h8000_0000, 24'hFFFFFF);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 24'h000001);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 24'h800000);
        send_sample(32'h0001_0000, 32'hFFFF_0000, 24'h004189);
        send_sample(32'hFFFF_FFFF, 32'h0000_0001, 24'h7FFFFF);
        // zero noise: all three noise registers written to zero
        write_noise(CFG_ANGLE_NOISE, '0);
        write_noise(CFG_BIAS_NOISE, '0);
        write_noise(CFG_MEASURE_NOISE, '0);
        send_sample(32'h0005_0000, 32'h0001_0000, 24'h004189);
        send_sample(32'hFFFB_0000, 32'h0000_0000, 24'h000000);
        // maximum noise
        write_noise(CFG_ANGLE_NOISE, '1);
        write_noise(CFG_BIAS_NOISE, '1);
        write_noise(CFG_MEASURE_NOISE, '1);
        repeat (4) send_sample($urandom(), $urandom(), 24'($urandom()));
        write_noise(CFG_ANGLE_NOISE, RESET_ANGLE_NOISE);
        write_noise(CFG_BIAS_NOISE, RESET_BIAS_NOISE);
        write_noise(CFG_MEASURE_NOISE, RESET_MEASURE_NOISE);
        // random phases, each with fresh noise settings
        for (phase = 0; phase < 5; phase++) begin
            write_noise(CFG_ANGLE_NOISE, NoiseW'($urandom_range(0, 1 << 26)));
            write_noise(CFG_BIAS_NOISE, NoiseW'($urandom()));
            write_noise(CFG_MEASURE_NOISE, (phase == 2) ? NoiseW'(1) : NoiseW'($urandom()));
            if (phase == 1) hold_off = 1'b1;
            if (phase == 4) calm = 1'b1;
            repeat (100) send_sample(rand_angle(), rand_angle(), rand_dt());
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        $display("ran %0d samples and %0d noise writes, %0d estimates checked",
                 samples_sent, writes_done, estimates_seen);
        $display("covered field extremes, zero variance, max noise and a long output stall");
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/kabf_pkg.sv
hdl/kabf_ctrl.sv
hdl/kabf_dp.sv
hdl/kalman_angle_bias_filter_core.sv
bench/kalman_checker.sv
bench/testbench.sv
